// ----- design/spq_pkg.sv -----
// Package for the sorted priority queue: sizes, codes, entry and bus types, index helper.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int PRIO_W = 8;
	localparam int OCC_W  = 5;
	localparam int ACT_W  = 2;
	localparam int STAT_W = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_ENQ  = 2'd0,
		ACT_DEQ  = 2'd1,
		ACT_PEEK = 2'd2
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_INS,
		S_HEAD,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [PRIO_W-1:0]        prio;
		logic signed [DATA_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		entry_t           wdata;
		logic [PTR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] data;
		logic [PRIO_W-1:0]        prio;
		logic [OCC_W-1:0]         occ;
	} result_t;

	// Physical slot of a logical position in the circular store.
	function automatic logic [PTR_W-1:0] spq_wrap(input logic [PTR_W-1:0] base,
		input logic [PTR_W-1:0] off);
		logic [PTR_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (PTR_W+1)'(DEPTH)) begin
			sum = sum - (PTR_W+1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- design/spq_in_if.sv -----
// Request channel of the sorted priority queue: action, data word and priority.
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if
	import spq_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic signed [DATA_W-1:0] item_data;
	logic [PRIO_W-1:0]        item_priority;

	modport source (output valid, output action, output item_data, output item_priority,
		input ready);
	modport sink (input valid, input action, input item_data, input item_priority,
		output ready);
endinterface

`default_nettype wire

// ----- design/spq_out_if.sv -----
// Response channel of the sorted priority queue: status, head entry and occupancy.
`timescale 1ns / 1ps
`default_nettype none

interface spq_out_if
	import spq_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] head_data;
	logic [PRIO_W-1:0]        head_priority;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, output status, output head_data, output head_priority,
		output occupancy, input ready);
	modport sink (input valid, input status, input head_data, input head_priority,
		input occupancy, output ready);
endinterface

`default_nettype wire

// ----- design/spq_mem.sv -----
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module spq_mem
	import spq_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_req_t req,
	output entry_t        rd_q
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_q <= mem_q[req.raddr];
	end

endmodule

`default_nettype wire

// ----- design/spq_ctrl.sv -----
// Sequencer: head pointer, count and the insertion walk over the store.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
	import spq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire action_t  req_action,
	input  wire entry_t   req_item,
	output mem_req_t      mem_req,
	input  wire entry_t   rd_q,
	output logic          res_valid,
	input  wire logic     res_ready,
	output result_t       res
);

	state_t               st_q, st_next;
	logic [CNT_W-1:0]     count_q;
	logic [PTR_W-1:0]     head_q;
	logic [PTR_W-1:0]     pos_q;
	action_t              act_q;
	entry_t               item_q;
	status_t              res_status_q;
	logic signed [DATA_W-1:0] res_data_q;
	logic [PRIO_W-1:0]    res_prio_q;

	logic                 full, empty, shift, req_fire;
	logic [CNT_W-1:0]     count_m1;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign shift    = (rd_q.prio < item_q.prio);
	assign count_m1 = count_q - CNT_W'(1);
	assign req_fire = req_valid && req_ready;

	always_comb begin
		st_next = st_q;
		case (st_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_action)
						ACT_ENQ: begin
							if (full) begin
								st_next = S_RESP;
							end else if (empty) begin
								st_next = S_INS;
							end else begin
								st_next = S_CMP;
							end
						end
						ACT_DEQ, ACT_PEEK: st_next = empty ? S_RESP : S_HEAD;
						default: st_next = S_RESP;
					endcase
				end
			end
			S_CMP: begin
				if (shift && (pos_q != PTR_W'(1))) begin
					st_next = S_CMP;
				end else begin
					st_next = S_INS;
				end
			end
			S_INS:  st_next = S_RESP;
			S_HEAD: st_next = S_RESP;
			S_RESP: begin
				if (res_ready) begin
					st_next = S_IDLE;
				end
			end
			default: st_next = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready     = 1'b0;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = spq_wrap(head_q, pos_q);
		mem_req.wdata = item_q;
		mem_req.raddr = head_q;
		case (st_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_action == ACT_ENQ) begin
					mem_req.raddr = spq_wrap(head_q, count_m1[PTR_W-1:0]);
				end
			end
			S_CMP: begin
				mem_req.raddr = spq_wrap(head_q, pos_q - PTR_W'(2));
				if (shift) begin
					mem_req.we    = 1'b1;
					mem_req.wdata = rd_q;
				end
			end
			S_INS:  mem_req.we = 1'b1;
			S_RESP: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res.status = res_status_q;
	assign res.data   = res_data_q;
	assign res.prio   = res_prio_q;
	assign res.occ    = OCC_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			count_q <= '0;
			head_q  <= '0;
		end else begin
			st_q <= st_next;
			if (st_q == S_INS) begin
				count_q <= count_q + CNT_W'(1);
			end
			if ((st_q == S_HEAD) && (act_q == ACT_DEQ)) begin
				head_q  <= spq_wrap(head_q, PTR_W'(1));
				count_q <= count_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			act_q        <= req_action;
			item_q       <= req_item;
			pos_q        <= count_q[PTR_W-1:0];
			res_data_q   <= '0;
			res_prio_q   <= '0;
			res_status_q <= STAT_OK;
			case (req_action)
				ACT_ENQ:  if (full)  res_status_q <= STAT_OVERFLOW;
				ACT_DEQ:  if (empty) res_status_q <= STAT_UNDERFLOW;
				ACT_PEEK: if (empty) res_status_q <= STAT_EMPTY;
				default: ;
			endcase
		end
		if ((st_q == S_CMP) && shift) begin
			pos_q <= pos_q - PTR_W'(1);
		end
		if (st_q == S_HEAD) begin
			res_data_q <= rd_q.data;
			res_prio_q <= rd_q.prio;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond store depth");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (st_q != S_IDLE))
		else $error("sequencer idle right after taking a request");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_status_q == STAT_OVERFLOW)) |-> full)
		else $error("overflow reported with room in the store");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> ((st_q == S_CMP) || (st_q == S_INS)))
		else $error("store written outside the insertion walk");
`endif

endmodule

`default_nettype wire

// ----- design/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: sequencer, entry store and response register.
//
//  channel  dir  beat fields                                         handshake
//  req      in   action, item_data, item_priority                    valid/ready
//  rsp      out  status, head_data, head_priority, occupancy          valid/ready
//
// One request is worked on at a time. Errors and the unused action go straight to the
// response; dequeue and peek first read the head, and an enqueue into an empty store
// writes its entry directly. Any other enqueue first walks the store: the insertion
// walk reads one entry per cycle through the single read port of the store and writes
// it one place down.
// Reset returns the sequencer to idle and clears the count, head pointer and response
// valid; the store itself is never cleared, as nothing beyond the count is ever read.
// The response register lets a finished beat wait for rsp.ready while the next request
// is taken; a request finishing while that beat still waits holds in its last state.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue
	import spq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	spq_in_if.sink    req,
	spq_out_if.source rsp
);

	mem_req_t mem_req;
	entry_t   rd_q;
	entry_t   req_item;
	logic     res_valid;
	logic     res_ready;
	result_t  res;
	logic     out_vld_q;
	result_t  out_q;

	// The store is a circular buffer: dequeue only advances the head pointer, while
	// enqueue walks from the tail towards the head, moving lower-priority entries down.
	assign req_item.data = req.item_data;
	assign req_item.prio = req.item_priority;

	spq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_action (action_t'(req.action)),
		.req_item   (req_item),
		.mem_req    (mem_req),
		.rd_q       (rd_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	spq_mem u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rd_q (rd_q)
	);

	// Response register: loads when empty or when its beat leaves in the same cycle.
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = out_q.status;
	assign rsp.head_data     = out_q.data;
	assign rsp.head_priority = out_q.prio;
	assign rsp.occupancy     = out_q.occ;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the sorted priority queue: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;
	import spq_pkg::*;

	// Action code three has no meaning. The block must answer it with an OK status,
	// zero head fields and the current occupancy, and leave the store untouched.
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	// This margin covers the longest request and the drain at the end.
	localparam int SETTLE_CYCLES = DEPTH + 8;
	localparam int DRAIN_LIMIT   = 4000;

	// One expected response beat, held until the block delivers it.
	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] head_data;
		logic [PRIO_W-1:0]        head_prio;
		logic [OCC_W-1:0]         occ;
	} queue_reply_t;

	logic clk;
	logic arst_n;

	spq_in_if  req_if ();
	spq_out_if rsp_if ();

	sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// The testbench keeps its own copy of the sorted store. Slot 0 is always the head,
	// and entries of equal priority stay in the order in which they arrived.
	logic signed [DATA_W-1:0] shadow_data [DEPTH];
	logic [PRIO_W-1:0]        shadow_prio [DEPTH];
	int                       shadow_count;

	// Response beats predicted but not yet seen on the response channel, oldest first.
	queue_reply_t replies_due[$];

	// Idle rates in percent for the request side and the response side. The test tasks
	// change these between phases.
	int src_idle_pct;
	int snk_idle_pct;

	int mismatches;
	int requests_sent;
	int replies_checked;
	int status_seen [4];
	int deepest_walk;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// This process stops a run that hangs. It allows far more time than the slowest
	// legal run needs.
	initial begin
		#(10_000_000);
		$display("Timed out with %0d response beats outstanding.", replies_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t ns] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// This function applies one request to the copy of the store and returns the response
	// that the request should produce. An enqueue walks from the tail towards the head.
	// It moves every entry of strictly lower priority one place down, so the new entry
	// lands after all entries of equal or higher priority.
	function automatic queue_reply_t predict_reply(input logic [ACT_W-1:0] act,
		input logic signed [DATA_W-1:0] word, input logic [PRIO_W-1:0] prio);
		queue_reply_t r;
		int           slot;
		r.status    = STAT_OK;
		r.head_data = '0;
		r.head_prio = '0;
		case (act)
			ACT_ENQ: begin
				if (shadow_count >= DEPTH) begin
					r.status = STAT_OVERFLOW;
				end else begin
					slot = shadow_count;
					while (slot > 0 && shadow_prio[slot-1] < prio) begin
						shadow_data[slot] = shadow_data[slot-1];
						shadow_prio[slot] = shadow_prio[slot-1];
						slot--;
					end
					if (shadow_count - slot > deepest_walk) begin
						deepest_walk = shadow_count - slot;
					end
					shadow_data[slot] = word;
					shadow_prio[slot] = prio;
					shadow_count++;
				end
			end
			ACT_DEQ: begin
				if (shadow_count == 0) begin
					r.status = STAT_UNDERFLOW;
				end else begin
					r.head_data = shadow_data[0];
					r.head_prio = shadow_prio[0];
					for (int i = 0; i + 1 < shadow_count; i++) begin
						shadow_data[i] = shadow_data[i+1];
						shadow_prio[i] = shadow_prio[i+1];
					end
					shadow_count--;
				end
			end
			ACT_PEEK: begin
				if (shadow_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.head_data = shadow_data[0];
					r.head_prio = shadow_prio[0];
				end
			end
			default: begin
			end
		endcase
		r.occ = OCC_W'(shadow_count);
		return r;
	endfunction

	// This task sends one request beat. It may first hold valid low, as src_idle_pct sets. It
	// returns just after the edge at which the beat was taken, with valid still high. A
	// back-to-back beat therefore keeps valid high without lowering it in the same step.
	// The prediction is made at acceptance. A response can only follow a later edge.
	task automatic send_request(input logic [ACT_W-1:0] act,
		input logic signed [DATA_W-1:0] word, input logic [PRIO_W-1:0] prio);
		int           gap;
		queue_reply_t r;
		if ($urandom_range(99) < src_idle_pct) begin
			gap = $urandom_range(4, 1);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.action        <= act;
		req_if.item_data     <= word;
		req_if.item_priority <= prio;
		do @(posedge clk); while (!req_if.ready);
		r = predict_reply(act, word, prio);
		replies_due.push_back(r);
		status_seen[r.status]++;
		requests_sent++;
	endtask

	task automatic check_reply();
		queue_reply_t exp;
		if (replies_due.size() == 0) begin
			report_mismatch($sformatf("response beat with nothing expected (status %0d)",
				rsp_if.status));
		end else begin
			exp = replies_due.pop_front();
			if (rsp_if.status !== exp.status) begin
				report_mismatch($sformatf("status got %0d expected %0d",
					rsp_if.status, exp.status));
			end
			if (rsp_if.head_data !== exp.head_data) begin
				report_mismatch($sformatf("head_data got %h expected %h",
					rsp_if.head_data, exp.head_data));
			end
			if (rsp_if.head_priority !== exp.head_prio) begin
				report_mismatch($sformatf("head_priority got %0d expected %0d",
					rsp_if.head_priority, exp.head_prio));
			end
			if (rsp_if.occupancy !== exp.occ) begin
				report_mismatch($sformatf("occupancy got %0d expected %0d",
					rsp_if.occupancy, exp.occ));
			end
			replies_checked++;
		end
	endtask

	// The response side samples the handshake as it stood before each edge. It then
	// decides whether ready is high for the next cycle.
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				check_reply();
			end
			rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// This task covers the empty store. A peek reports empty and a dequeue reports
	// underflow. The unused action is ignored even when its data and priority fields
	// are set.
	task automatic test_empty_store();
		send_request(ACT_PEEK, 32'sd0, 8'd0);
		send_request(ACT_DEQ, -32'sd1, 8'hFF);
		send_request(ACT_UNUSED, 32'sh5A5A_A5A5, 8'hC3);
	endtask

	// This task fills the store to DEPTH with extreme data words and priorities,
	// including runs of equal priority. One more enqueue must then be refused. A peek
	// and the unused action on the full store follow. Three dequeues then check that the
	// highest priority leaves first and that ties leave in arrival order. The rest of
	// the store drains during the random phases.
	task automatic test_fill_and_order();
		logic [PRIO_W-1:0] prio_list [DEPTH];
		logic signed [DATA_W-1:0] word;
		prio_list = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd255, 8'd7, 8'd0, 8'd200,
			8'd128, 8'd1, 8'd255, 8'd64, 8'd0, 8'd128, 8'd200, 8'd254};
		for (int i = 0; i < DEPTH; i++) begin
			case (i)
				0: word = 32'sh7FFF_FFFF;
				1: word = 32'sh8000_0000;
				2: word = 32'sd0;
				3: word = -32'sd1;
				4: word = 32'shAAAA_5555;
				default: word = 32'sh1000_0000 + i;
			endcase
			send_request(ACT_ENQ, word, prio_list[i]);
		end
		send_request(ACT_ENQ, 32'sh1234_5678, 8'd255);
		send_request(ACT_PEEK, 32'sh0F0F_0F0F, 8'd9);
		send_request(ACT_UNUSED, -32'sd2, 8'd255);
		repeat (3) send_request(ACT_DEQ, 32'sd0, 8'd0);
	endtask

	// This task sends random traffic in bursts that lean towards filling or draining.
	// The store therefore sweeps often between empty and full, and overflow and
	// underflow occur many times. Priorities come partly from a few values, which gives
	// many ties, and partly from the whole range, which sets every bit. Data words are
	// random or extreme. Peeks and unused codes are mixed in throughout.
	task automatic random_traffic(input int count);
		int                       burst_left;
		bit                       filling;
		int                       roll;
		logic [ACT_W-1:0]         act;
		logic signed [DATA_W-1:0] word;
		logic [PRIO_W-1:0]        prio;
		burst_left = 0;
		filling    = 1'b1;
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 8);
				filling    = 1'($urandom_range(1));
			end
			burst_left--;
			roll = $urandom_range(99);
			if (roll < 3) begin
				act = ACT_UNUSED;
			end else if (roll < 13) begin
				act = ACT_PEEK;
			end else if (roll < (filling ? 78 : 35)) begin
				act = ACT_ENQ;
			end else begin
				act = ACT_DEQ;
			end
			case ($urandom_range(3))
				0: prio = $urandom_range(1) ? 8'd255 : 8'd0;
				1: prio = PRIO_W'($urandom_range(4, 1) * 50);
				default: prio = PRIO_W'($urandom_range(255));
			endcase
			case ($urandom_range(15))
				0: word = 32'sh7FFF_FFFF;
				1: word = 32'sh8000_0000;
				default: word = $urandom;
			endcase
			send_request(act, word, prio);
		end
	endtask

	task automatic test_slow_receiver();
		src_idle_pct = 27;
		snk_idle_pct = 67;
		random_traffic(400);
	endtask

	task automatic test_slow_sender();
		src_idle_pct = 67;
		snk_idle_pct = 27;
		random_traffic(420);
	endtask

	task automatic test_full_rate();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_traffic(410);
	endtask

	// This task lowers valid and keeps ready high. It waits for the last response, and
	// then waits a little longer so that any stray beat shows up as a mismatch.
	task automatic drain_and_settle();
		int waited;
		req_if.valid <= 1'b0;
		snk_idle_pct = 0;
		waited = 0;
		while (replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (replies_due.size() != 0) begin
			report_mismatch($sformatf("%0d response beats never arrived",
				replies_due.size()));
		end
	endtask

	initial begin
		arst_n               <= 1'b0;
		req_if.valid         <= 1'b0;
		req_if.action        <= ACT_ENQ;
		req_if.item_data     <= '0;
		req_if.item_priority <= '0;
		shadow_count = 0;
		src_idle_pct = 27;
		snk_idle_pct = 67;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed checks run with the first pair of idle rates.
		test_empty_store();
		test_fill_and_order();
		test_slow_receiver();
		test_slow_sender();
		test_full_rate();
		drain_and_settle();

		$display("Checked %0d of %0d requests; deepest insertion walk %0d entries.",
			replies_checked, requests_sent, deepest_walk);
		$display("Seen: %0d ok, %0d overflow, %0d underflow, %0d empty peek; %0d mismatches.",
			status_seen[STAT_OK], status_seen[STAT_OVERFLOW],
			status_seen[STAT_UNDERFLOW], status_seen[STAT_EMPTY], mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/spq_pkg.sv
design/spq_in_if.sv
design/spq_out_if.sv
design/spq_mem.sv
design/spq_ctrl.sv
design/sorted_priority_queue.sv
dv/tb_top.sv
